// File: design/rrts_pkg.sv
// shared types, constants and codes for the round-robin task scheduler
`default_nettype none

package rrts_pkg;

  // sizes
  localparam int NUM_TASKS = 16;
  localparam int TASK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int SLICE_W   = 8;
  localparam int STATUS_W  = 2;
  localparam int REQ_W     = 2;
  localparam int SLOT_W    = 2;
  localparam int KIND_W    = 3;

  // slice of task 0 after reset
  localparam logic [SLICE_W-1:0] RESET_SLICE = SLICE_W'(2);

  // request codes
  localparam logic [REQ_W-1:0] REQ_ALLOC  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SLEEP  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_SWITCH = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOFREE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_IGNORED = 2'd2;

  // slot states
  localparam logic [SLOT_W-1:0] SLOT_FREE  = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_ALLOC = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_RUN   = 2'd2;

  // kinds of result the datapath can build
  localparam logic [KIND_W-1:0] RES_ALLOC  = 3'd0;
  localparam logic [KIND_W-1:0] RES_NOFREE = 3'd1;
  localparam logic [KIND_W-1:0] RES_CUR    = 3'd2;
  localparam logic [KIND_W-1:0] RES_IGNORE = 3'd3;
  localparam logic [KIND_W-1:0] RES_SWITCH = 3'd4;
  localparam logic [KIND_W-1:0] RES_EMPTY  = 3'd5;

  // input transaction
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [TASK_W-1:0]  task_id;
    logic [SLICE_W-1:0] slice_ticks;
  } request_t;

  // result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TASK_W-1:0]   result_task;
    logic                load_timer;
    logic [SLICE_W-1:0]  timer_ticks;
    logic                do_switch;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic              load;
    logic              alloc_sel;
    logic              idx_inc;
    logic              alloc_mark;
    logic              run_update;
    logic              latch_cur;
    logic              sleep_remove;
    logic              shift_step;
    logic              sleep_fix;
    logic              sw_advance;
    logic              sw_empty;
    logic              rl_idx;
    logic              rl_plus1;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic slot_free;
    logic slot_running;
    logic idx_last;
    logic idx_end;
    logic match;
    logic count_zero;
  } stat_t;

endpackage

`default_nettype wire

// File: design/round_robin_task_scheduler_top.sv
// top level of the round-robin task scheduler
//
// channel   direction  handshake             payload
// request   in         start & !busy         rrts_pkg::request_t
// result    out        done (one cycle)      rrts_pkg::result_t
//
// run goes through S_RUN and S_REPORT, switch through S_SW_ADV and S_SW_REPORT (S_SW_ADV alone
// on an empty list), allocate scans the slots (one slot per cycle), sleep stops in S_SLP_CHK when
// ignored, else searches the list and compacts it (one entry per cycle), then S_SLP_FIX, S_REPORT;
// done is registered from the last controller step, and busy is low again when it shows.
// synchronous reset leaves task 0 running alone with slice 2.
// the receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module round_robin_task_scheduler_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire rrts_pkg::request_t request,
  output logic                    done,
  output rrts_pkg::result_t       result
);

  rrts_pkg::cmd_t  cmd;
  rrts_pkg::stat_t stat;

  // control
  rrts_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  // tables and result register
  rrts_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .stat    (stat),
    .result  (result),
    .done    (done)
  );

endmodule

`default_nettype wire

// File: design/rrts_dp.sv
// datapath: slot table, run list, counters and result register
`default_nettype none

module rrts_dp (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rrts_pkg::request_t request,
  input  wire rrts_pkg::cmd_t    cmd,
  output rrts_pkg::stat_t        stat,
  output rrts_pkg::result_t      result,
  output logic                   done
);

  localparam int TW = rrts_pkg::TASK_W;
  localparam int CW = rrts_pkg::COUNT_W;
  localparam logic [CW-1:0] NUM_C  = CW'(rrts_pkg::NUM_TASKS);
  localparam logic [CW-1:0] LAST_C = CW'(rrts_pkg::NUM_TASKS - 1);

  logic [rrts_pkg::SLOT_W-1:0]  slot_state [rrts_pkg::NUM_TASKS];
  logic [rrts_pkg::SLICE_W-1:0] slot_slice [rrts_pkg::NUM_TASKS];
  logic [TW-1:0]                run_list   [rrts_pkg::NUM_TASKS];
  logic [CW-1:0]                count;
  logic [TW-1:0]                pos;
  logic [CW-1:0]                idx;
  logic [TW-1:0]                req_tid;
  logic [rrts_pkg::SLICE_W-1:0] req_slice;
  logic                         was_cur;

  logic [TW-1:0]                ss_addr;
  logic [rrts_pkg::SLOT_W-1:0]  ss_val;
  logic [TW-1:0]                rl_addr;
  logic [TW-1:0]                rl_val;
  logic                         cur_ok;
  logic [TW-1:0]                cur_task;
  logic [rrts_pkg::SLICE_W-1:0] cur_slice;
  logic [CW-1:0]                pos_inc;
  rrts_pkg::result_t            result_next;

  // slot table read port
  assign ss_addr = cmd.alloc_sel ? idx[TW-1:0] : req_tid;
  assign ss_val  = slot_state[ss_addr];

  // run list read port: current position, scan index or the entry after it
  assign rl_addr = cmd.rl_idx ? (idx[TW-1:0] + (cmd.rl_plus1 ? TW'(1) : TW'(0))) : pos;
  assign rl_val  = run_list[rl_addr];

  // current task, valid when the read port sits on the position
  assign cur_ok    = (count != '0) && ({1'b0, pos} < count);
  assign cur_task  = cur_ok ? rl_val : '0;
  assign cur_slice = slot_slice[cur_task];
  assign pos_inc   = {1'b0, pos} + CW'(1);

  // status to controller
  always_comb begin
    stat.slot_free    = (ss_val == rrts_pkg::SLOT_FREE);
    stat.slot_running = (ss_val == rrts_pkg::SLOT_RUN);
    stat.idx_last     = (idx == LAST_C);
    stat.idx_end      = (idx >= count);
    stat.match        = (rl_val == req_tid);
    stat.count_zero   = (count == '0);
  end

  // result selection
  always_comb begin
    result_next = '0;
    case (cmd.emit_kind)
      rrts_pkg::RES_ALLOC: begin
        result_next.status      = rrts_pkg::STAT_OK;
        result_next.result_task = idx[TW-1:0];
      end
      rrts_pkg::RES_NOFREE: begin
        result_next.status = rrts_pkg::STAT_NOFREE;
      end
      rrts_pkg::RES_CUR: begin
        result_next.status      = rrts_pkg::STAT_OK;
        result_next.result_task = cur_task;
        result_next.do_switch   = was_cur && (count != '0);
      end
      rrts_pkg::RES_IGNORE: begin
        result_next.status      = rrts_pkg::STAT_IGNORED;
        result_next.result_task = cur_task;
      end
      rrts_pkg::RES_SWITCH: begin
        result_next.status      = rrts_pkg::STAT_OK;
        result_next.result_task = cur_task;
        result_next.load_timer  = 1'b1;
        result_next.timer_ticks = cur_slice;
        result_next.do_switch   = (count >= CW'(2));
      end
      default: begin
        result_next = '0;
      end
    endcase
  end

  // scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rrts_pkg::NUM_TASKS; i++) begin
        slot_state[i] <= rrts_pkg::SLOT_FREE;
        slot_slice[i] <= '0;
        run_list[i]   <= '0;
      end
      slot_state[0] <= rrts_pkg::SLOT_RUN;
      slot_slice[0] <= rrts_pkg::RESET_SLICE;
      count         <= CW'(1);
      pos           <= '0;
      idx           <= '0;
      was_cur       <= 1'b0;
    end else begin
      // new transaction
      if (cmd.load) begin
        req_tid   <= request.task_id;
        req_slice <= request.slice_ticks;
        idx       <= '0;
        was_cur   <= 1'b0;
      end
      if (cmd.idx_inc) begin
        idx <= idx + CW'(1);
      end
      // allocate: claim the scanned slot
      if (cmd.alloc_mark) begin
        slot_state[idx[TW-1:0]] <= rrts_pkg::SLOT_ALLOC;
      end
      // run: update slice, append to list
      if (cmd.run_update) begin
        if (req_slice != '0) begin
          slot_slice[req_tid] <= req_slice;
        end
        if (ss_val != rrts_pkg::SLOT_RUN && count < NUM_C) begin
          slot_state[req_tid]       <= rrts_pkg::SLOT_RUN;
          run_list[count[TW-1:0]]   <= req_tid;
          count                     <= count + CW'(1);
        end
      end
      // sleep: remember whether the task is current
      if (cmd.latch_cur) begin
        was_cur <= cur_ok && (rl_val == req_tid);
      end
      // sleep: drop the entry and pull the position back
      if (cmd.sleep_remove) begin
        count <= count - CW'(1);
        if (idx < {1'b0, pos}) begin
          pos <= pos - TW'(1);
        end
      end
      // sleep: compact one entry per cycle
      if (cmd.shift_step) begin
        run_list[idx[TW-1:0]] <= rl_val;
        idx                   <= idx + CW'(1);
      end
      if (cmd.sleep_fix) begin
        slot_state[req_tid] <= rrts_pkg::SLOT_ALLOC;
        if ({1'b0, pos} >= count) begin
          pos <= '0;
        end
      end
      // switch: advance cyclically
      if (cmd.sw_advance) begin
        pos <= (pos_inc >= count) ? '0 : pos_inc[TW-1:0];
      end
      if (cmd.sw_empty) begin
        pos <= '0;
      end
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

// File: design/rrts_ctrl.sv
// controller: sequences each request through the datapath
`default_nettype none

module rrts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire rrts_pkg::request_t request,
  input  wire rrts_pkg::stat_t    stat,
  output rrts_pkg::cmd_t          cmd,
  output logic                    busy
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_ALLOC     = 4'd1;
  localparam logic [3:0] S_RUN       = 4'd2;
  localparam logic [3:0] S_SLP_CHK   = 4'd3;
  localparam logic [3:0] S_SLP_FIND  = 4'd4;
  localparam logic [3:0] S_SLP_SHIFT = 4'd5;
  localparam logic [3:0] S_SLP_FIX   = 4'd6;
  localparam logic [3:0] S_REPORT    = 4'd7;
  localparam logic [3:0] S_SW_ADV    = 4'd8;
  localparam logic [3:0] S_SW_REPORT = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign busy = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (request.req_type)
            rrts_pkg::REQ_ALLOC: state_next = S_ALLOC;
            rrts_pkg::REQ_RUN:   state_next = S_RUN;
            rrts_pkg::REQ_SLEEP: state_next = S_SLP_CHK;
            default:             state_next = S_SW_ADV;
          endcase
        end
      end
      // scan slots for the lowest free one
      S_ALLOC: begin
        cmd.alloc_sel = 1'b1;
        if (stat.slot_free) begin
          cmd.alloc_mark = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_kind  = rrts_pkg::RES_ALLOC;
          state_next     = S_IDLE;
        end else if (stat.idx_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = rrts_pkg::RES_NOFREE;
          state_next    = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_RUN: begin
        cmd.run_update = 1'b1;
        state_next     = S_REPORT;
      end
      // sleep of a task that is not running is ignored
      S_SLP_CHK: begin
        if (!stat.slot_running) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = rrts_pkg::RES_IGNORE;
          state_next    = S_IDLE;
        end else begin
          cmd.latch_cur = 1'b1;
          state_next    = S_SLP_FIND;
        end
      end
      // look for the task in the run list
      S_SLP_FIND: begin
        cmd.rl_idx = 1'b1;
        if (stat.idx_end) begin
          state_next = S_SLP_FIX;
        end else if (stat.match) begin
          cmd.sleep_remove = 1'b1;
          state_next       = S_SLP_SHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // close the gap one entry at a time
      S_SLP_SHIFT: begin
        cmd.rl_idx   = 1'b1;
        cmd.rl_plus1 = 1'b1;
        if (stat.idx_end) begin
          state_next = S_SLP_FIX;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_SLP_FIX: begin
        cmd.sleep_fix = 1'b1;
        state_next    = S_REPORT;
      end
      S_REPORT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = rrts_pkg::RES_CUR;
        state_next    = S_IDLE;
      end
      S_SW_ADV: begin
        if (stat.count_zero) begin
          cmd.sw_empty  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = rrts_pkg::RES_EMPTY;
          state_next    = S_IDLE;
        end else begin
          cmd.sw_advance = 1'b1;
          state_next     = S_SW_REPORT;
        end
      end
      S_SW_REPORT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = rrts_pkg::RES_SWITCH;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: tb/rrts_checker.sv
// scoreboard for the round-robin task scheduler: predicts every request and checks each result
`timescale 1ns / 1ps

module rrts_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire rrts_pkg::request_t request,
  input  wire logic               done,
  input  wire rrts_pkg::result_t  result,
  output int                      fail_count,
  output int                      pending
);

  localparam int NT = rrts_pkg::NUM_TASKS;
  localparam int TW = rrts_pkg::TASK_W;

  // shadow copy of the scheduler tables
  logic [rrts_pkg::SLOT_W-1:0]  slot_mode    [NT];
  logic [rrts_pkg::SLICE_W-1:0] slot_quantum [NT];
  logic [TW-1:0]                ready_list   [NT];
  int                           ready_len;
  int                           ready_pos;

  rrts_pkg::result_t expected_results[$];
  int                errs;

  // task at the current position, 0 when the list is empty
  function automatic logic [TW-1:0] current_task();
    if (ready_len == 0 || ready_pos >= ready_len) return '0;
    return ready_list[ready_pos];
  endfunction

  // apply one request to the shadow tables and build the result it should give
  task automatic apply_request(input rrts_pkg::request_t rq, output rrts_pkg::result_t res);
    int            idx;
    int            hit;
    logic          found;
    logic          was_current;
    logic [TW-1:0] t;
    res = '0;
    case (rq.req_type)
      rrts_pkg::REQ_ALLOC: begin
        found = 1'b0;
        for (idx = 0; idx < NT; idx++) begin
          if (!found && slot_mode[idx] == rrts_pkg::SLOT_FREE) begin
            found = 1'b1;
            slot_mode[idx] = rrts_pkg::SLOT_ALLOC;
            res.result_task = TW'(idx);
          end
        end
        res.status = found ? rrts_pkg::STAT_OK : rrts_pkg::STAT_NOFREE;
      end
      rrts_pkg::REQ_RUN: begin
        // a 4-bit id always names a real slot with 16 tasks
        if (rq.slice_ticks != '0) slot_quantum[rq.task_id] = rq.slice_ticks;
        if (slot_mode[rq.task_id] != rrts_pkg::SLOT_RUN && ready_len < NT) begin
          slot_mode[rq.task_id] = rrts_pkg::SLOT_RUN;
          ready_list[ready_len] = rq.task_id;
          ready_len++;
        end
        res.status = rrts_pkg::STAT_OK;
        res.result_task = current_task();
      end
      rrts_pkg::REQ_SLEEP: begin
        if (slot_mode[rq.task_id] != rrts_pkg::SLOT_RUN) begin
          res.status = rrts_pkg::STAT_IGNORED;
          res.result_task = current_task();
        end else begin
          was_current = (ready_len > 0 && current_task() == rq.task_id);
          hit = ready_len;
          for (idx = 0; idx < ready_len; idx++)
            if (hit == ready_len && ready_list[idx] == rq.task_id) hit = idx;
          // drop the entry and close the gap
          if (hit < ready_len) begin
            ready_len--;
            if (hit < ready_pos) ready_pos--;
            for (idx = hit; idx < ready_len; idx++) ready_list[idx] = ready_list[idx + 1];
          end
          slot_mode[rq.task_id] = rrts_pkg::SLOT_ALLOC;
          if (ready_pos >= ready_len) ready_pos = 0;
          res.status = rrts_pkg::STAT_OK;
          res.result_task = current_task();
          res.do_switch = was_current && ready_len > 0;
        end
      end
      default: begin
        // slice expiry: step to the next task in the list
        res.status = rrts_pkg::STAT_OK;
        if (ready_len == 0) begin
          ready_pos = 0;
        end else begin
          ready_pos++;
          if (ready_pos >= ready_len) ready_pos = 0;
          t = current_task();
          res.result_task = t;
          res.load_timer = 1'b1;
          res.timer_ticks = slot_quantum[t];
          res.do_switch = ready_len >= 2;
        end
      end
    endcase
  endtask

  // watch both channels on every edge
  always @(posedge clk) begin
    rrts_pkg::result_t exp_res;
    rrts_pkg::result_t new_res;
    if (rst) begin
      for (int i = 0; i < NT; i++) begin
        slot_mode[i] = rrts_pkg::SLOT_FREE;
        slot_quantum[i] = '0;
        ready_list[i] = '0;
      end
      slot_mode[0] = rrts_pkg::SLOT_RUN;
      slot_quantum[0] = rrts_pkg::RESET_SLICE;
      ready_len = 1;
      ready_pos = 0;
      expected_results.delete();
      errs = 0;
    end else begin
      // result transaction against the oldest expectation
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result: none expected, got status %0d task %0d",
                 result.status, result.result_task);
          errs++;
        end else begin
          exp_res = expected_results.pop_front();
          if (result.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, result.status);
            errs++;
          end
          if (result.result_task !== exp_res.result_task) begin
            $error("result_task: expected %0d, got %0d",
                   exp_res.result_task, result.result_task);
            errs++;
          end
          if (result.load_timer !== exp_res.load_timer) begin
            $error("load_timer: expected %0d, got %0d",
                   exp_res.load_timer, result.load_timer);
            errs++;
          end
          if (result.timer_ticks !== exp_res.timer_ticks) begin
            $error("timer_ticks: expected %0d, got %0d",
                   exp_res.timer_ticks, result.timer_ticks);
            errs++;
          end
          if (result.do_switch !== exp_res.do_switch) begin
            $error("do_switch: expected %0d, got %0d", exp_res.do_switch, result.do_switch);
            errs++;
          end
        end
      end
      // request transaction
      if (start && !busy) begin
        apply_request(request, new_res);
        expected_results.push_back(new_res);
      end
    end
    fail_count <= errs;
    pending <= expected_results.size();
  end

endmodule

// File: tb/tb_top.sv
// top of the round-robin task scheduler testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int PHASE_ITEMS = 275;
  localparam int TW          = rrts_pkg::TASK_W;
  localparam int SW          = rrts_pkg::SLICE_W;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  rrts_pkg::request_t request;
  logic               done;
  rrts_pkg::result_t  result;
  int                 fail_count;
  int                 pending;
  int                 cycle_count;
  int                 idle_pct;

  round_robin_task_scheduler_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  rrts_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .request    (request),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // drive one request and hold it until the block takes it, then maybe go quiet
  task automatic issue(input logic [rrts_pkg::REQ_W-1:0] kind, input logic [TW-1:0] tid,
                       input logic [SW-1:0] ticks);
    rrts_pkg::request_t rq;
    rq.req_type = kind;
    rq.task_id = tid;
    rq.slice_ticks = ticks;
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
  endtask

  int                           phase;
  int                           n;
  int                           pick;
  int                           w_alloc;
  int                           w_run;
  int                           w_sleep;
  logic [rrts_pkg::REQ_W-1:0]   kind;
  logic [SW-1:0]                ticks;

  // stimulus
  initial begin
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    idle_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single task, empty list, free slot run, sleeps around the position
    issue(rrts_pkg::REQ_SWITCH, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_RUN, 4'd0, 8'd255);
    issue(rrts_pkg::REQ_SWITCH, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_SLEEP, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_SWITCH, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_RUN, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_RUN, 4'd15, 8'd0);
    issue(rrts_pkg::REQ_RUN, 4'd3, 8'd1);
    issue(rrts_pkg::REQ_SWITCH, 4'd7, 8'd170);
    issue(rrts_pkg::REQ_SLEEP, 4'd15, 8'd0);
    issue(rrts_pkg::REQ_SLEEP, 4'd0, 8'd0);
    issue(rrts_pkg::REQ_SWITCH, 4'd0, 8'd0);
    // claim every free slot, then one more with none left
    repeat (14) issue(rrts_pkg::REQ_ALLOC, 4'd15, 8'd255);
    issue(rrts_pkg::REQ_SLEEP, 4'd9, 8'd0);

    // random phases: list length drifts with the run and sleep mix
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;  w_alloc = 8; w_run = 32; w_sleep = 25;
        end
        1: begin
          idle_pct = 49; w_alloc = 5; w_run = 15; w_sleep = 50;
        end
        2: begin
          idle_pct = 0;  w_alloc = 5; w_run = 40; w_sleep = 20;
        end
        default: begin
          idle_pct = 37; w_alloc = 8; w_run = 30; w_sleep = 30;
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < w_alloc) kind = rrts_pkg::REQ_ALLOC;
        else if (pick < w_alloc + w_run) kind = rrts_pkg::REQ_RUN;
        else if (pick < w_alloc + w_run + w_sleep) kind = rrts_pkg::REQ_SLEEP;
        else kind = rrts_pkg::REQ_SWITCH;
        pick = $urandom_range(99);
        if (pick < 25) ticks = '0;
        else if (pick < 35) ticks = '1;
        else ticks = SW'($urandom_range(255));
        issue(kind, TW'($urandom_range(15)), ticks);
      end
    end
    start <= 1'b0;

    // drain and let any stray result show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
